### rtl/core/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared constants and types of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int DEF_PAGE_TOTAL = 256;
  localparam int WORD_BITS      = 32;
  localparam int BIT_W          = 5;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  // lowest set bit of one map word
  typedef struct packed {
    logic                 found;
    logic [BIT_W-1:0]     idx;
    logic [WORD_BITS-1:0] onehot;
  } bpfa_ffs_t;

endpackage

### rtl/core/bpfa_ffs.sv
// ----------------------------------------------------------------------------
// bpfa_ffs
// Find-first-set unit: isolates the lowest set bit of a map word and encodes
// its position.
// ----------------------------------------------------------------------------
module bpfa_ffs
  import bpfa_pkg::*;
(
  input  logic [WORD_BITS-1:0] word_i,
  output bpfa_ffs_t            res_o
);

  logic [WORD_BITS-1:0] onehot;
  logic [BIT_W-1:0]     idx;

  // two's complement trick leaves only the lowest one
  assign onehot = word_i & (~word_i + WORD_BITS'(1));

  always_comb begin
    idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      for (int k = 0; k < BIT_W; k++) begin
        idx[k] = idx[k] | (onehot[b] & b[k]);
      end
    end
  end

  assign res_o.found  = |word_i;
  assign res_o.idx    = idx;
  assign res_o.onehot = onehot;

endmodule

### rtl/core/bitmap_page_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_top
// First-fit page allocator over a free bitmap held in a word-wide memory,
// with a free page counter and a reserved low region set by os_pages.
// ----------------------------------------------------------------------------
//  channel   direction  signals                               handshake
//  request   in         req_type_i, page_i                    start_i & !busy_o
//  result    out        alloc_page_o, ok_o, free_count_o      done_o, one cycle
//  config    in         os_pages_i                            os_pages_we_i
//
//  Allocate reads map words from word 0 up, one word examined a cycle
//  through the find-first unit, limited by the single map read port, and
//  stops at the first hit; a full miss reads every word. Free: one
//  read-modify-write while busy. Init: one word written a cycle. Empty alloc,
//  bad free and unknown requests answer in the next cycle without going busy.
//  After reset the map is filled by the same sweep while busy_o is high.
//  The receiver cannot stall; done_o lasts one cycle.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_top
  import bpfa_pkg::*;
#(
  parameter int PAGE_TOTAL = DEF_PAGE_TOTAL
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       os_pages_we_i,
  input  logic [8:0] os_pages_i,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] page_i,
  output logic       done_o,
  output logic [7:0] alloc_page_o,
  output logic       ok_o,
  output logic [8:0] free_count_o
);

  localparam int MAP_WORDS = (PAGE_TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(PAGE_TOTAL + 1);
  localparam int FW        = (CW > 9) ? CW : 9;
  localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);
  localparam logic [CW-1:0] CNT_MAX   = CW'(PAGE_TOTAL);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FREE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [WW-1:0]        idx_q, idx_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic [FW-1:0]        first_q, first_d;
  logic                 report_q, report_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [8:0]           os_pages_q;
  logic                 done_q, done_d;
  logic                 ok_q, ok_d;
  logic [7:0]           page_q, page_d;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [WW-1:0]        raddr;
  logic                 we;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] init_word;

  logic                 accept;
  logic [FW-1:0]        os_ext;
  logic [FW-1:0]        first_new;
  logic [WW+2:0]        page_word_ext;
  logic [WW+12:0]       grant_ext;
  logic [CW+8:0]        cnt_ext;
  logic [WW+BIT_W-1:0]  pg;
  bpfa_ffs_t            ffs;

  bpfa_ffs u_ffs (
    .word_i (rdata_q),
    .res_o  (ffs)
  );

  assign accept        = start_i & ~busy_o;
  assign os_ext        = FW'(os_pages_q);
  assign first_new     = (os_ext > FW'(PAGE_TOTAL)) ? FW'(PAGE_TOTAL) : os_ext;
  assign page_word_ext = {{WW{1'b0}}, page_i[7:5]};
  assign grant_ext     = {8'b0, idx_q, ffs.idx};
  assign cnt_ext       = {9'b0, cnt_q};

  // free bits of the word under the init sweep
  always_comb begin
    init_word = '0;
    pg        = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      pg = {idx_q, BIT_W'(b)};
      init_word[b] = (pg >= first_q) && (pg < PAGE_TOTAL);
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    bit_d    = bit_q;
    first_d  = first_q;
    report_d = report_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    ok_d     = 1'b0;
    page_d   = 8'd0;
    raddr    = idx_q;
    we       = 1'b0;
    wdata    = init_word;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_ALLOC: begin
              raddr = '0;
              if (cnt_q == '0) begin
                done_d = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = ST_SCAN;
              end
            end
            REQ_FREE: begin
              if (page_i < PAGE_TOTAL) begin
                raddr   = page_word_ext[WW-1:0];
                idx_d   = page_word_ext[WW-1:0];
                bit_d   = page_i[4:0];
                state_d = ST_FREE;
              end else begin
                done_d = 1'b1;
              end
            end
            REQ_INIT: begin
              first_d  = first_new;
              cnt_d    = CNT_MAX - CW'(first_new);
              idx_d    = '0;
              report_d = 1'b1;
              state_d  = ST_INIT;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_INIT: begin
        we    = 1'b1;
        wdata = init_word;
        if (idx_q == LAST_WORD) begin
          done_d  = report_q;
          ok_d    = report_q;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + WW'(1);
        end
      end
      ST_SCAN: begin
        // rdata_q holds word idx_q; prefetch the next one
        raddr = (idx_q == LAST_WORD) ? idx_q : idx_q + WW'(1);
        if (ffs.found) begin
          we      = 1'b1;
          wdata   = rdata_q & ~ffs.onehot;
          cnt_d   = cnt_q - CW'(1);
          done_d  = 1'b1;
          ok_d    = 1'b1;
          page_d  = grant_ext[7:0];
          state_d = ST_IDLE;
        end else if (idx_q == LAST_WORD) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + WW'(1);
        end
      end
      ST_FREE: begin
        we    = 1'b1;
        wdata = rdata_q | (WORD_BITS'(1) << bit_q);
        if (cnt_q != CNT_MAX) begin
          cnt_d = cnt_q + CW'(1);
        end
        done_d  = 1'b1;
        ok_d    = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      idx_q      <= '0;
      first_q    <= '0;
      report_q   <= 1'b0;
      cnt_q      <= CNT_MAX;
      os_pages_q <= 9'd0;
      done_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      first_q  <= first_d;
      report_q <= report_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      if (os_pages_we_i) begin
        os_pages_q <= os_pages_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    ok_q   <= ok_d;
    page_q <= page_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign alloc_page_o = page_q;
  assign free_count_o = cnt_ext[8:0];

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("free count above page total");

  a_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> busy_o)
    else $error("map written while idle");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (alloc_page_o == 8'd0))
    else $error("failed beat carries a page");

  a_alloc_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && ffs.found) |=> (cnt_q == $past(cnt_q) - CW'(1)) && done_o)
    else $error("grant did not drop the count");

  a_scan_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_INIT) |-> (idx_q <= LAST_WORD))
    else $error("word index past the map");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit page allocator. A clocked driver
// feeds alloc, free, init and unknown requests from a queue. A monitor
// predicts each result from its own copy of the free map, the free count and
// os_pages, then compares every done beat with the oldest prediction.
// os_pages is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench
  import bpfa_pkg::*;
;

  localparam int PAGE_TOTAL = DEF_PAGE_TOTAL;
  localparam int MAP_WORDS  = PAGE_TOTAL / WORD_BITS;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] page;
  } page_req_t;

  typedef struct packed {
    logic [7:0] page;
    logic       ok;
    logic [8:0] count;
  } grant_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       os_pages_we_i = 1'b0;
  logic [8:0] os_pages_i    = '0;
  logic       start_i       = 1'b0;
  logic [1:0] req_type_i    = '0;
  logic [7:0] page_i        = '0;
  logic       busy_o;
  logic       done_o;
  logic [7:0] alloc_page_o;
  logic       ok_o;
  logic [8:0] free_count_o;

  bitmap_page_frame_allocator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .os_pages_we_i(os_pages_we_i),
    .os_pages_i   (os_pages_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .page_i       (page_i),
    .done_o       (done_o),
    .alloc_page_o (alloc_page_o),
    .ok_o         (ok_o),
    .free_count_o (free_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predicted allocator state
  logic [31:0] free_map [MAP_WORDS];
  logic [8:0]  free_pages;
  logic [8:0]  os_pages_cfg;

  page_req_t req_pending[$];
  grant_t    grant_expected[$];

  int beats_in     = 0;
  int beats_popped = 0;
  int idle_pct     = 0;
  bit drain_hold   = 1'b0;
  int mismatches   = 0;

  function automatic void reinit_map();
    int first;
    first = (os_pages_cfg > PAGE_TOTAL) ? PAGE_TOTAL : int'(os_pages_cfg);
    for (int p = 0; p < PAGE_TOTAL; p++) begin
      free_map[p / WORD_BITS][p % WORD_BITS] = (p >= first);
    end
    free_pages = 9'(PAGE_TOTAL - first);
  endfunction

  function automatic grant_t serve_request(page_req_t rq);
    grant_t r;
    bit     hit;
    r   = '0;
    hit = 1'b0;
    case (rq.kind)
      REQ_ALLOC: begin
        if (free_pages != 0) begin
          for (int w = 0; w < MAP_WORDS; w++) begin
            for (int b = 0; b < WORD_BITS; b++) begin
              if (!hit && free_map[w][b]) begin
                hit               = 1'b1;
                r.page            = 8'(w * WORD_BITS + b);
                free_map[w][b]    = 1'b0;
              end
            end
          end
          if (hit) begin
            free_pages = free_pages - 9'd1;
            r.ok       = 1'b1;
          end
        end
      end
      REQ_FREE: begin
        free_map[rq.page[7:5]][rq.page[4:0]] = 1'b1;
        if (free_pages < PAGE_TOTAL) free_pages = free_pages + 9'd1;
        r.ok = 1'b1;
      end
      REQ_INIT: begin
        reinit_map();
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.count = free_pages;
    return r;
  endfunction

  // monitor: check done beats, predict accepted request beats
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni) begin
      if (os_pages_we_i) os_pages_cfg = os_pages_i;
      if (done_o === 1'b1) begin
        if (grant_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: page %0d ok %0b count %0d",
                     alloc_page_o, ok_o, free_count_o);
        end else begin
          want = grant_expected.pop_front();
          if (alloc_page_o !== want.page || ok_o !== want.ok ||
              free_count_o !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: page %0d/%0d ok %0b/%0b count %0d/%0d (exp/act)",
                       want.page, alloc_page_o, want.ok, ok_o,
                       want.count, free_count_o);
          end
        end
      end
      if (start_i && busy_o === 1'b0) begin
        grant_expected.push_back(serve_request(page_req_t'{kind: req_type_i,
                                                           page: page_i}));
        beats_in++;
      end
    end
  end

  // driver: present the head of the queue until the block takes it
  always @(negedge clk_i) begin
    bit taken;
    taken = (beats_popped != beats_in);
    if (taken) begin
      beats_popped++;
      void'(req_pending.pop_front());
    end
    if (!(start_i && !taken)) begin
      if (drain_hold) begin
        if (grant_expected.size() == 0) drain_hold = 1'b0;
        start_i <= 1'b0;
      end else if (req_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        if (idle_pct != 0 && $urandom_range(0, 63) == 0) begin
          // hold off until every outstanding result is back
          drain_hold = 1'b1;
          start_i <= 1'b0;
        end else begin
          start_i    <= 1'b1;
          req_type_i <= req_pending[0].kind;
          page_i     <= req_pending[0].page;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  function automatic void push_req(logic [1:0] kind, logic [7:0] pg);
    req_pending.push_back(page_req_t'{kind: kind, page: pg});
  endfunction

  task automatic wait_drained();
    while (req_pending.size() != 0 || grant_expected.size() != 0) @(negedge clk_i);
    while (busy_o !== 1'b0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_os_pages(logic [8:0] value);
    @(negedge clk_i);
    os_pages_we_i <= 1'b1;
    os_pages_i    <= value;
    @(negedge clk_i);
    os_pages_we_i <= 1'b0;
  endtask

  initial begin
    int         left;
    int         run;
    int         roll;
    int         os_val;
    int         lo_base;
    logic [1:0] kind;
    logic [7:0] pg;
    int         os_table [10];

    os_table     = '{0, 1, 31, 200, 256, 32, 128, 511, 255, 0};
    os_pages_cfg = '0;
    reinit_map();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: first fit, double frees, unknown request
    idle_pct = 8;
    push_req(REQ_ALLOC, 8'h00);
    push_req(REQ_ALLOC, 8'hFF);
    push_req(REQ_ALLOC, 8'h00);
    push_req(REQ_FREE, 8'd1);
    push_req(REQ_ALLOC, 8'h00);
    push_req(REQ_FREE, 8'd255);
    push_req(REQ_FREE, 8'd0);
    push_req(REQ_FREE, 8'd0);
    push_req(REQ_UNKNOWN, 8'hFF);
    push_req(REQ_UNKNOWN, 8'h00);
    push_req(REQ_INIT, 8'hFF);
    wait_drained();

    // everything reserved; count runs ahead of the map after a double free
    set_os_pages(9'd256);
    push_req(REQ_INIT, 8'h00);
    push_req(REQ_ALLOC, 8'h00);
    push_req(REQ_FREE, 8'd7);
    push_req(REQ_FREE, 8'd7);
    push_req(REQ_ALLOC, 8'h00);
    push_req(REQ_ALLOC, 8'h00);
    push_req(REQ_FREE, 8'd0);
    push_req(REQ_FREE, 8'd128);
    push_req(REQ_ALLOC, 8'h00);
    wait_drained();

    // oversized os_pages
    set_os_pages(9'd511);
    push_req(REQ_INIT, 8'h00);
    push_req(REQ_ALLOC, 8'h00);
    wait_drained();

    // one page left above the reserved area, then free a reserved one
    set_os_pages(9'd255);
    push_req(REQ_INIT, 8'h00);
    push_req(REQ_ALLOC, 8'h00);
    push_req(REQ_ALLOC, 8'h00);
    push_req(REQ_FREE, 8'd254);
    push_req(REQ_ALLOC, 8'h00);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      os_val   = (ph == 9) ? $urandom_range(0, 511) : os_table[ph];
      idle_pct = (ph < 4) ? 8 : (ph < 7) ? 56 : 0;
      lo_base  = (os_val > 192) ? 192 : os_val;
      set_os_pages(9'(os_val));
      push_req(REQ_INIT, 8'($urandom_range(0, 255)));
      left = 110;
      while (left > 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          kind = REQ_ALLOC;
          run  = $urandom_range(1, 24);
        end else if (roll < 75) begin
          kind = REQ_FREE;
          run  = $urandom_range(1, 8);
        end else if (roll < 80) begin
          // long alloc run to push the map into exhaustion
          kind = REQ_ALLOC;
          run  = $urandom_range(40, 80);
        end else if (roll < 83) begin
          kind = REQ_INIT;
          run  = 1;
        end else if (roll < 87) begin
          kind = REQ_UNKNOWN;
          run  = 1;
        end else begin
          kind = 2'($urandom_range(0, 3));
          run  = 1;
        end
        for (int k = 0; k < run && left > 0; k++) begin
          if (kind == REQ_FREE && $urandom_range(0, 1) == 1)
            pg = 8'(lo_base + $urandom_range(0, 63));
          else
            pg = 8'($urandom_range(0, 255));
          push_req(kind, pg);
          left--;
        end
      end
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (grant_expected.size() != 0)
      $display("%0d results never arrived", grant_expected.size());
    if (mismatches == 0 && grant_expected.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
